@@ design/cdcc_pkg.sv @@
// cdcc_pkg: opcodes, configuration indexes, controller command and status structs
// and the sigmoid lookup table for the causal depthwise convolution core
// no dependencies
package cdcc_pkg;

    localparam int unsigned OPCODE_W  = 3;
    localparam int unsigned TAP_IDX_W = 4;

    localparam logic [OPCODE_W-1:0] OP_LOAD_WEIGHT  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_BIAS    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_HISTORY = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ_HISTORY = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE       = 3'd4;

    localparam logic CFG_BIAS_ENABLE       = 1'b0;
    localparam logic CFG_ACTIVATION_ENABLE = 1'b1;

    localparam logic RESULT_FILTERED = 1'b0;
    localparam logic RESULT_HISTORY  = 1'b1;

    typedef struct packed {
        logic                 latch;
        logic                 wr_weight;
        logic                 wr_bias;
        logic                 wr_hist;
        logic                 rd_item;
        logic                 issue_weight;
        logic                 issue_hist;
        logic                 issue_bias;
        logic                 proc;
        logic                 proc_sample;
        logic                 shift_wr;
        logic                 acc_clear;
        logic                 acc_final;
        logic                 round;
        logic                 silu_mul;
        logic                 silu_fin;
        logic                 res_read;
        logic                 out_load;
        logic [TAP_IDX_W-1:0] idx;
    } cdcc_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                ch_ok;
        logic                weight_ok;
        logic                hist_ok;
        logic                sample_ok;
        logic                act_en;
        logic                out_free;
    } cdcc_status_t;

    // sigmoid in Q1.15 for t = (k-128)/8, exp(-t) built by repeated multiply
    function automatic logic [16*256-1:0] build_sig_table();
        logic [63:0]         p;
        logic [63:0]         den;
        logic [63:0]         num;
        logic [63:0]         rem;
        logic [63:0]         s;
        logic [16*256-1:0]   t;
        t = '0;
        p = 64'd1 << 32;
        for (int m = 0; m <= 128; m++)
        begin
            den = (64'd1 << 32) + p;
            num = (64'd1 << 47) + (den >> 1);
            rem = '0;
            s   = '0;
            // restoring long division, evaluated at elaboration
            for (int i = 63; i >= 0; i--)
            begin
                rem = {rem[62:0], num[i]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    s[i] = 1'b1;
                end
            end
            if (m <= 127)
            begin
                t[(128 + m)*16 +: 16] = s[15:0];
            end
            if (m >= 1)
            begin
                t[(128 - m)*16 +: 16] = 16'd32768 - s[15:0];
            end
            p = (p * 64'd3790295335 + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam logic [16*256-1:0] SIG_TABLE = build_sig_table();

endpackage

@@ design/cdcc_datapath.sv @@
// cdcc_datapath: item registers, weight/bias/history memories, tap multiplier,
// accumulator, rounding, sigmoid-weighted activation and output register
// depends on cdcc_pkg
module cdcc_datapath #(
    parameter int TAPS     = 4,
    parameter int CHANNELS = 64,
    parameter int SLOTS    = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic                       cfg_data,
    input  logic [2:0]                 opcode,
    input  logic [3:0]                 slot,
    input  logic [5:0]                 channel,
    input  logic [2:0]                 tap,
    input  logic signed [15:0]         sample_value,
    input  logic                       first_of_sequence,
    input  logic                       use_initial,
    input  cdcc_pkg::cdcc_cmd_t        cmd,
    output cdcc_pkg::cdcc_status_t     st,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic                       result_kind,
    output logic [3:0]                 out_slot,
    output logic [5:0]                 out_channel,
    output logic signed [15:0]         out_value
);
    import cdcc_pkg::*;

    localparam int HLEN   = TAPS - 1;
    localparam int WDEPTH = CHANNELS * TAPS;
    localparam int HDEPTH = SLOTS * CHANNELS * HLEN;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int BAW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

    logic signed [15:0] wmem [WDEPTH];
    logic signed [15:0] bmem [CHANNELS];
    logic signed [15:0] hmem [HDEPTH];

    logic [2:0]         op_reg;
    logic [3:0]         slot_reg;
    logic [5:0]         ch_reg;
    logic [2:0]         tap_reg;
    logic signed [15:0] val_reg;
    logic               first_reg;
    logic               keep_reg;

    logic               bias_en_reg;
    logic               act_en_reg;

    logic signed [15:0] w_rdata_reg;
    logic signed [15:0] b_rdata_reg;
    logic signed [15:0] h_rdata_reg;

    logic signed [31:0] prod_reg;
    logic               prod_valid_reg;
    logic signed [35:0] acc_reg;
    logic signed [35:0] acc_next;
    logic signed [15:0] res_reg;
    logic signed [32:0] sprod_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [3:0]         out_slot_reg;
    logic [5:0]         out_ch_reg;
    logic signed [15:0] out_value_reg;

    int                 w_base;
    int                 h_base;
    logic [WAW-1:0]     w_rd_addr;
    logic [WAW-1:0]     w_wr_addr;
    logic [BAW-1:0]     b_addr;
    logic [HAW-1:0]     h_rd_addr;
    logic [HAW-1:0]     h_wr_addr;
    logic signed [15:0] h_wr_data;
    logic               h_we;
    logic signed [15:0] win;
    logic signed [35:0] acc_rnd;
    logic signed [21:0] acc_sh;
    logic signed [15:0] y_sat;
    logic [16:0]        k_sum;
    logic [7:0]         k_idx;
    logic [15:0]        sig_val;
    logic signed [32:0] sp_rnd;
    logic signed [17:0] sp_sh;
    logic signed [15:0] silu_sat;

    // item and configuration registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= opcode;
            slot_reg  <= slot;
            ch_reg    <= channel;
            tap_reg   <= tap;
            val_reg   <= sample_value;
            first_reg <= first_of_sequence;
            keep_reg  <= use_initial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_en_reg <= 1'b0;
            act_en_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_BIAS_ENABLE)
            begin
                bias_en_reg <= cfg_data;
            end
            if (cfg_index == CFG_ACTIVATION_ENABLE)
            begin
                act_en_reg <= cfg_data;
            end
        end
    end

    // range checks
    always_comb
    begin
        st.op        = op_reg;
        st.ch_ok     = int'(ch_reg) < CHANNELS;
        st.weight_ok = st.ch_ok && (int'(tap_reg) < TAPS);
        st.hist_ok   = st.ch_ok && (int'(slot_reg) < SLOTS) && (int'(tap_reg) < HLEN);
        st.sample_ok = st.ch_ok && (int'(slot_reg) < SLOTS);
        st.act_en    = act_en_reg;
        st.out_free  = !out_valid_reg || !out_stall;
    end

    // addresses
    always_comb
    begin
        w_base    = int'(ch_reg) * TAPS;
        h_base    = (int'(slot_reg) * CHANNELS + int'(ch_reg)) * HLEN;
        w_rd_addr = WAW'(w_base + int'(cmd.idx));
        w_wr_addr = WAW'(w_base + int'(tap_reg));
        b_addr    = BAW'(ch_reg);
        h_rd_addr = cmd.rd_item ? HAW'(h_base + int'(tap_reg))
                                : HAW'(h_base + int'(cmd.idx));
        win       = cmd.proc_sample ? val_reg
                  : ((first_reg && !keep_reg) ? 16'sd0 : h_rdata_reg);
        h_we      = cmd.wr_hist || cmd.shift_wr;
        h_wr_addr = cmd.wr_hist ? HAW'(h_base + int'(tap_reg))
                                : HAW'(h_base + int'(cmd.idx) - 2);
        h_wr_data = cmd.wr_hist ? val_reg : win;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.wr_weight)
        begin
            wmem[w_wr_addr] <= val_reg;
        end
        if (cmd.issue_weight)
        begin
            w_rdata_reg <= wmem[w_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_bias)
        begin
            bmem[b_addr] <= val_reg;
        end
        if (cmd.issue_bias)
        begin
            b_rdata_reg <= bmem[b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[h_wr_addr] <= h_wr_data;
        end
        if (cmd.issue_hist || cmd.rd_item)
        begin
            h_rdata_reg <= hmem[h_rd_addr];
        end
    end

    // multiply, accumulate, round
    always_comb
    begin
        acc_next = acc_reg;
        if (prod_valid_reg)
        begin
            acc_next = acc_next + 36'(prod_reg);
        end
        if (cmd.acc_final && bias_en_reg)
        begin
            acc_next = acc_next + {{6{b_rdata_reg[15]}}, b_rdata_reg, 14'd0};
        end
        if (cmd.acc_clear)
        begin
            acc_next = '0;
        end
        acc_rnd = acc_reg + 36'sd8192;
        acc_sh  = acc_rnd[35:14];
        if (acc_sh > 22'sd32767)
        begin
            y_sat = 16'sd32767;
        end
        else if (acc_sh < -22'sd32768)
        begin
            y_sat = -16'sd32768;
        end
        else
        begin
            y_sat = acc_sh[15:0];
        end
        k_sum   = {1'b0, res_reg ^ 16'h8000} + 17'd128;
        k_idx   = k_sum[16] ? 8'hFF : k_sum[15:8];
        sig_val = SIG_TABLE[k_idx*16 +: 16];
        sp_rnd  = sprod_reg + 33'sd16384;
        sp_sh   = sp_rnd[32:15];
        if (sp_sh > 18'sd32767)
        begin
            silu_sat = 16'sd32767;
        end
        else if (sp_sh < -18'sd32768)
        begin
            silu_sat = -16'sd32768;
        end
        else
        begin
            silu_sat = sp_sh[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.proc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.proc)
        begin
            prod_reg <= win * w_rdata_reg;
        end
        acc_reg <= acc_next;
        if (cmd.silu_mul)
        begin
            sprod_reg <= res_reg * $signed({1'b0, sig_val});
        end
        if (cmd.round)
        begin
            res_reg <= y_sat;
        end
        else if (cmd.silu_fin)
        begin
            res_reg <= silu_sat;
        end
        else if (cmd.res_read)
        begin
            res_reg <= st.hist_ok ? h_rdata_reg : 16'sd0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg  <= (op_reg == OP_READ_HISTORY) ? RESULT_HISTORY : RESULT_FILTERED;
            out_slot_reg  <= slot_reg;
            out_ch_reg    <= ch_reg;
            out_value_reg <= res_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign out_slot    = out_slot_reg;
    assign out_channel = out_ch_reg;
    assign out_value   = out_value_reg;

endmodule

@@ design/cdcc_ctrl.sv @@
// cdcc_ctrl: one-hot state machine that sequences item decode, the tap loop,
// rounding, activation and result hand-off for the datapath
// depends on cdcc_pkg
module cdcc_ctrl #(
    parameter int TAPS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  cdcc_pkg::cdcc_status_t st,
    output cdcc_pkg::cdcc_cmd_t    cmd
);
    import cdcc_pkg::*;

    localparam int HLEN = TAPS - 1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_READ     = 9'b000000100,
        S_TAP      = 9'b000001000,
        S_SUM      = 9'b000010000,
        S_ROUND    = 9'b000100000,
        S_SILU_MUL = 9'b001000000,
        S_SILU_FIN = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [TAP_IDX_W-1:0] cnt_reg;
    logic [TAP_IDX_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (st.op)
                    OP_LOAD_WEIGHT:  cmd.wr_weight = st.weight_ok;
                    OP_LOAD_BIAS:    cmd.wr_bias   = st.ch_ok;
                    OP_LOAD_HISTORY: cmd.wr_hist   = st.hist_ok;
                    OP_READ_HISTORY:
                    begin
                        cmd.rd_item = st.hist_ok;
                        state_next  = S_READ;
                    end
                    OP_SAMPLE:
                    begin
                        if (st.sample_ok)
                        begin
                            cmd.acc_clear = 1'b1;
                            cnt_next      = '0;
                            state_next    = S_TAP;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_READ:
            begin
                cmd.res_read = 1'b1;
                state_next   = S_DONE;
            end
            S_TAP:
            begin
                cmd.issue_weight = int'(cnt_reg) < TAPS;
                cmd.issue_hist   = int'(cnt_reg) < HLEN;
                cmd.issue_bias   = (cnt_reg == '0);
                cmd.proc         = (cnt_reg != '0);
                cmd.proc_sample  = int'(cnt_reg) == TAPS;
                cmd.shift_wr     = int'(cnt_reg) >= 2;
                cnt_next         = cnt_reg + 1'b1;
                if (int'(cnt_reg) == TAPS)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.acc_final = 1'b1;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = st.act_en ? S_SILU_MUL : S_DONE;
            end
            S_SILU_MUL:
            begin
                cmd.silu_mul = 1'b1;
                state_next   = S_SILU_FIN;
            end
            S_SILU_FIN:
            begin
                cmd.silu_fin = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over a pending result");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EXEC))
        else $error("accepted item not decoded");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP) |-> (int'(cnt_reg) <= TAPS))
        else $error("tap counter out of range");

    a_one_hist_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_hist && cmd.shift_wr))
        else $error("two history writes in one cycle");

endmodule

@@ design/causal_depthwise_conv_cached_core.sv @@
// causal_depthwise_conv_cached_core: top level of the per-channel causal FIR
// with per-slot history cache; depends on cdcc_pkg, cdcc_ctrl, cdcc_datapath
//
// Usage: items arrive on in_valid/in_stall with opcode, slot, channel, tap,
// sample_value, first_of_sequence and use_initial. Opcodes load a weight, a
// bias or a history word, read a history word back, or filter one sample.
// Results leave on out_valid/out_stall: result_kind, out_slot, out_channel,
// out_value. Loads and dropped items give none; out-of-range reads give 0.
// Configuration (bias_enable index 0, activation_enable index 1) is written
// through cfg_write/cfg_index/cfg_data while the block is idle.
// One item is worked at a time. A sample is decoded, then runs the tap loop,
// sum and rounding, plus sigmoid steps with activation, before out_valid.
// The tap loop does one multiply per cycle over one weight and history port.
// in_stall is low whenever the block is idle; a new item is taken while the
// previous result still sits in the output register.
// If out_stall holds, the result stays unchanged and the next finished result
// waits until the output register frees.
// Reset clears control state and both configuration bits; the weight, bias and
// history memories hold no defined value until written.
module causal_depthwise_conv_cached_core #(
    parameter int TAPS     = 4,
    parameter int CHANNELS = 64,
    parameter int SLOTS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [3:0]         slot,
    input  logic [5:0]         channel,
    input  logic [2:0]         tap,
    input  logic signed [15:0] sample_value,
    input  logic               first_of_sequence,
    input  logic               use_initial,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [3:0]         out_slot,
    output logic [5:0]         out_channel,
    output logic signed [15:0] out_value
);
    import cdcc_pkg::*;

    cdcc_cmd_t    cmd;
    cdcc_status_t st;

    cdcc_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    cdcc_datapath #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS),
        .SLOTS    (SLOTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .opcode            (opcode),
        .slot              (slot),
        .channel           (channel),
        .tap               (tap),
        .sample_value      (sample_value),
        .first_of_sequence (first_of_sequence),
        .use_initial       (use_initial),
        .cmd               (cmd),
        .st                (st),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .result_kind       (result_kind),
        .out_slot          (out_slot),
        .out_channel       (out_channel),
        .out_value         (out_value)
    );

endmodule
